// File: rtl/utsph_pkg.sv
// utsph_pkg: types, constants and helper functions of the uv sphere tessellator
// shared by the divider and cordic cells, the record emitter, the top level and the checker
package utsph_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_SECTORS = 2'd1;
   localparam logic [1:0] CSR_STACKS = 2'd2;

   // record kinds
   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_TRIANGLE = 2'd1;
   localparam logic [1:0] KIND_RANGE = 2'd2;

   localparam int COUNT_MAX = 256;  // largest sector or stack count
   localparam int IDX_W = 9;        // grid index and count width
   localparam int DIV_W = 42;       // dividend and quotient width
   localparam int DIV_STEPS = DIV_W;
   localparam int REM_W = 10;       // divisor is twice a 9 bit count
   localparam int KW = 20;          // vertex index width
   localparam int CORDIC_STEPS = 30;
   localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   typedef struct packed {
      logic          valid;
      logic          oor;
      logic          up;
      logic          low;
      logic [KW-1:0] k1;
      logic [KW-1:0] k2;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DIV_W-1:0] dq;   // dividend bits shift out on top, quotient bits in below
   } div_lane_type;

   typedef struct packed {
      side_type     side;
      div_lane_type st;
      div_lane_type se;
   } div_type;

   typedef struct packed {
      logic [1:0]         quad;
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [32:0] z;
   } cordic_lane_type;

   typedef struct packed {
      side_type        side;
      cordic_lane_type st;
      cordic_lane_type se;
   } cordic_type;

   typedef struct packed {
      logic signed [31:0] c;
      logic signed [31:0] s;
   } trig_type;

   typedef struct packed {
      side_type           side;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } rec_type;

   function automatic logic signed [31:0] clamp_q30(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sd1073741824) begin
         r = 32'sd1073741824;
      end else if (v < -33'sd1073741824) begin
         r = -32'sd1073741824;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // quadrant fold of the first quadrant rotation, then clamp to one
   function automatic trig_type fold_trig(input cordic_lane_type l);
      trig_type t;
      unique case (l.quad)
         2'd0: begin
            t.c = clamp_q30(l.x);
            t.s = clamp_q30(l.y);
         end
         2'd1: begin
            t.c = clamp_q30(-l.y);
            t.s = clamp_q30(l.x);
         end
         2'd2: begin
            t.c = clamp_q30(-l.x);
            t.s = clamp_q30(-l.y);
         end
         default: begin
            t.c = clamp_q30(l.y);
            t.s = clamp_q30(-l.x);
         end
      endcase
      return t;
   endfunction

endpackage

// File: rtl/utsph_div_cell.sv
// utsph_div_cell: one restoring division step for the stack and sector phase lanes
// depends on utsph_pkg
module utsph_div_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic [utsph_pkg::REM_W-1:0] st_div,
   input  logic [utsph_pkg::REM_W-1:0] se_div,
   input  utsph_pkg::div_type          d_in,
   output utsph_pkg::div_type          d_ff
);
   import utsph_pkg::*;

   div_type d_nx;

   function automatic div_lane_type step(input div_lane_type l, input logic [REM_W-1:0] d);
      div_lane_type r;
      logic [REM_W:0] t;
      logic           ge;
      t = {l.rem, l.dq[DIV_W-1]};
      ge = (t >= {1'b0, d});
      r.rem = ge ? REM_W'(t - {1'b0, d}) : t[REM_W-1:0];
      r.dq = {l.dq[DIV_W-2:0], ge};
      return r;
   endfunction

   always_comb begin
      d_nx = d_in;
      d_nx.st = step(d_in.st, st_div);
      d_nx.se = step(d_in.se, se_div);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.side.valid <= 1'b0;
      end else if (enable) begin
         d_ff <= d_nx;
      end
   end

endmodule

// File: rtl/utsph_cordic_cell.sv
// utsph_cordic_cell: one cordic rotation of a fixed step for both angle lanes
// depends on utsph_pkg
module utsph_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  utsph_pkg::cordic_type c_in,
   output utsph_pkg::cordic_type c_ff
);
   import utsph_pkg::*;

   localparam logic signed [32:0] ANGLE = 33'(ATAN_TURNS[STEP]);

   cordic_type c_nx;

   function automatic cordic_lane_type rotate(input cordic_lane_type l);
      cordic_lane_type r;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      dx = l.y >>> STEP;
      dy = l.x >>> STEP;
      r.quad = l.quad;
      if (!l.z[32]) begin
         r.x = l.x - dx;
         r.y = l.y + dy;
         r.z = l.z - ANGLE;
      end else begin
         r.x = l.x + dx;
         r.y = l.y - dy;
         r.z = l.z + ANGLE;
      end
      return r;
   endfunction

   always_comb begin
      c_nx = c_in;
      c_nx.st = rotate(c_in.st);
      c_nx.se = rotate(c_in.se);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.side.valid <= 1'b0;
      end else if (enable) begin
         c_ff <= c_nx;
      end
   end

endmodule

// File: rtl/utsph_emit.sv
// utsph_emit: turns one finished grid point into its vertex and triangle words or one range word
// depends on utsph_pkg
module utsph_emit (
   input  logic               clock,
   input  logic               reset,
   input  utsph_pkg::rec_type in_rec,
   output logic               in_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [143:0]       rsp_tdata,   // value_a, value_b, value_c, normal_x, normal_y, normal_z
   output logic [1:0]         rsp_tuser,   // record_kind
   output logic               rsp_tlast    // last_record
);
   import utsph_pkg::*;

   typedef enum logic [1:0] {VERTEX_STEP, UPPER_STEP, LOWER_STEP} step_type;

   rec_type  hold_ff;
   logic     busy_ff;
   step_type step_ff;
   logic     cur_last;
   logic [31:0] ka;
   logic [31:0] kb;
   logic [31:0] kc;

   always_comb begin
      if (hold_ff.side.oor) begin
         cur_last = 1'b1;
      end else begin
         unique case (step_ff)
            VERTEX_STEP: cur_last = !(hold_ff.side.up || hold_ff.side.low);
            UPPER_STEP:  cur_last = !hold_ff.side.low;
            default:     cur_last = 1'b1;
         endcase
      end
   end

   assign in_ready = !busy_ff || (rsp_tready && cur_last);
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast = cur_last;

   always_comb begin
      ka = 32'(hold_ff.side.k1);
      kb = 32'(hold_ff.side.k2);
      kc = 32'(hold_ff.side.k1) + 32'd1;
      if (step_ff == LOWER_STEP) begin
         ka = 32'(hold_ff.side.k1) + 32'd1;
         kc = 32'(hold_ff.side.k2) + 32'd1;
      end
      if (hold_ff.side.oor) begin
         rsp_tuser = KIND_RANGE;
         rsp_tdata = '0;
      end else if (step_ff == VERTEX_STEP) begin
         rsp_tuser = KIND_VERTEX;
         rsp_tdata = {hold_ff.nz, hold_ff.ny, hold_ff.nx, hold_ff.z, hold_ff.y, hold_ff.x};
      end else begin
         rsp_tuser = KIND_TRIANGLE;
         rsp_tdata = {48'd0, kc, kb, ka};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= VERTEX_STEP;
      end else if (in_ready) begin
         busy_ff <= in_rec.side.valid;
         step_ff <= VERTEX_STEP;
         hold_ff <= in_rec;
      end else if (rsp_tready) begin
         // not last, so there is a following triangle word
         if (step_ff == VERTEX_STEP && hold_ff.side.up) begin
            step_ff <= UPPER_STEP;
         end else begin
            step_ff <= LOWER_STEP;
         end
      end
   end

endmodule

// File: rtl/uv_sphere_tessellator.sv
// uv sphere tessellator: takes one grid point (stack i, sector j) a cycle and returns its
// vertex word (Q16.16 position, Q2.14 normal) followed by up to two triangle index words,
// or a single out-of-range word. A new grid point is taken every cycle while the result
// port keeps up and a point gives one word; a point of two or three words holds the pipe
// as its words leave one per cycle; a backed-up result port stalls the whole pipe. From input
// to first word a point passes 42 divider cells that form the two angle phases one quotient
// bit each, 30 cordic cells for sine and cosine, one fold stage, two multiplier stages and
// the output word register. Counts are clamped when written.
module uv_sphere_tessellator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // stack_index, sector_index, zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // value_a, value_b, value_c, normal_x, normal_y, normal_z
   output logic [1:0]   rsp_tuser,   // record_kind
   output logic         rsp_tlast,   // last_record
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [30:0]  csr_wdata
);
   import utsph_pkg::*;

   function automatic logic [IDX_W-1:0] clamp_count(input logic [IDX_W-1:0] v,
                                                    input logic [IDX_W-1:0] lo);
      logic [IDX_W-1:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (int'(v) > COUNT_MAX) begin
         r = IDX_W'(COUNT_MAX);
      end
      return r;
   endfunction

   logic [30:0]      radius_ff;
   logic [IDX_W-1:0] sectors_ff;
   logic [IDX_W-1:0] stacks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 31'd65536;
         sectors_ff <= clamp_count(IDX_W'(36), IDX_W'(3));
         stacks_ff <= clamp_count(IDX_W'(18), IDX_W'(2));
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RADIUS:  radius_ff <= csr_wdata;
            CSR_SECTORS: sectors_ff <= clamp_count(csr_wdata[IDX_W-1:0], IDX_W'(3));
            CSR_STACKS:  stacks_ff <= clamp_count(csr_wdata[IDX_W-1:0], IDX_W'(2));
            default: ;
         endcase
      end
   end

   logic             pipe_en;
   logic             emit_ready;
   logic [IDX_W-1:0] st_i;
   logic [IDX_W-1:0] se_j;
   logic             inner;
   div_type          div_head;
   div_type          div_chain [DIV_STEPS+1];
   cordic_type       cor_head;
   cordic_type       cor_chain [CORDIC_STEPS+1];

   assign st_i = req_tdata[8:0];
   assign se_j = req_tdata[17:9];
   assign inner = (st_i < stacks_ff) && (se_j < sectors_ff);

   always_comb begin
      div_head.side.valid = req_tvalid;
      div_head.side.oor = (st_i > stacks_ff) || (se_j > sectors_ff);
      div_head.side.up = inner && (st_i != '0);
      div_head.side.low = inner && (st_i != stacks_ff - IDX_W'(1));
      div_head.side.k1 = KW'(st_i) * (KW'(sectors_ff) + KW'(1)) + KW'(se_j);
      div_head.side.k2 = div_head.side.k1 + KW'(sectors_ff) + KW'(1);
      // round(i * 2^31 / S) as (i * 2^32 + S) / 2S, likewise j * 2^33 + C over 2C
      div_head.st.rem = '0;
      div_head.st.dq = {1'b0, st_i, 32'd0} | DIV_W'(stacks_ff);
      div_head.se.rem = '0;
      div_head.se.dq = {se_j, 33'd0} | DIV_W'(sectors_ff);
   end

   assign div_chain[0] = div_head;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      utsph_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (pipe_en),
         .st_div ({stacks_ff, 1'b0}),
         .se_div ({sectors_ff, 1'b0}),
         .d_in   (div_chain[g]),
         .d_ff   (div_chain[g+1])
      );
   end

   logic [31:0] st_phase;
   logic [31:0] se_phase;

   assign st_phase = 32'h4000_0000 - div_chain[DIV_STEPS].st.dq[31:0];
   assign se_phase = div_chain[DIV_STEPS].se.dq[31:0];

   always_comb begin
      cor_head.side = div_chain[DIV_STEPS].side;
      cor_head.st.quad = st_phase[31:30];
      cor_head.st.x = CORDIC_K;
      cor_head.st.y = '0;
      cor_head.st.z = {3'b000, st_phase[29:0]};
      cor_head.se.quad = se_phase[31:30];
      cor_head.se.x = CORDIC_K;
      cor_head.se.y = '0;
      cor_head.se.z = {3'b000, se_phase[29:0]};
   end

   assign cor_chain[0] = cor_head;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      utsph_cordic_cell #(
         .STEP (g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (pipe_en),
         .c_in   (cor_chain[g]),
         .c_ff   (cor_chain[g+1])
      );
   end

   // fold stage
   side_type trig_side_ff;
   trig_type st_trig_ff;
   trig_type se_trig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_side_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         trig_side_ff <= cor_chain[CORDIC_STEPS].side;
         st_trig_ff <= fold_trig(cor_chain[CORDIC_STEPS].st);
         se_trig_ff <= fold_trig(cor_chain[CORDIC_STEPS].se);
      end
   end

   // first product stage: r cos(st), r sin(st), sin(st) to Q2.14
   logic signed [31:0] r_signed;
   logic signed [63:0] xy_prod;
   logic signed [63:0] z_prod;
   logic signed [32:0] nz_sum;

   assign r_signed = {1'b0, radius_ff};
   assign xy_prod = r_signed * st_trig_ff.c + 64'sd536870912;
   assign z_prod = r_signed * st_trig_ff.s + 64'sd536870912;
   assign nz_sum = {st_trig_ff.s[31], st_trig_ff.s} + 33'sd32768;

   side_type           m1_side_ff;
   logic signed [31:0] xy_ff;
   logic signed [31:0] z1_ff;
   logic signed [15:0] nz1_ff;
   logic signed [31:0] cst_ff;
   trig_type           se1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_side_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         m1_side_ff <= trig_side_ff;
         xy_ff <= xy_prod[61:30];
         z1_ff <= z_prod[61:30];
         nz1_ff <= nz_sum[31:16];
         cst_ff <= st_trig_ff.c;
         se1_ff <= se_trig_ff;
      end
   end

   // second product stage
   logic signed [63:0] x_prod;
   logic signed [63:0] y_prod;
   logic signed [63:0] nx_prod;
   logic signed [63:0] ny_prod;

   assign x_prod = xy_ff * se1_ff.c + 64'sd536870912;
   assign y_prod = xy_ff * se1_ff.s + 64'sd536870912;
   assign nx_prod = cst_ff * se1_ff.c + 64'sd35184372088832;
   assign ny_prod = cst_ff * se1_ff.s + 64'sd35184372088832;

   rec_type m2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_ff.side.valid <= 1'b0;
      end else if (pipe_en) begin
         m2_ff.side <= m1_side_ff;
         m2_ff.x <= x_prod[61:30];
         m2_ff.y <= y_prod[61:30];
         m2_ff.z <= z1_ff;
         m2_ff.nx <= nx_prod[61:46];
         m2_ff.ny <= ny_prod[61:46];
         m2_ff.nz <= nz1_ff;
      end
   end

   // the pipe moves when the word register takes the last stage or that stage is empty
   assign pipe_en = emit_ready || !m2_ff.side.valid;
   assign req_tready = pipe_en;

   utsph_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_rec     (m2_ff),
      .in_ready   (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/utsph_checker.sv
// utsph_checker: port level checks of the uv sphere tessellator, bound to the top level
// depends on utsph_pkg
module utsph_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [23:0]  req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic         csr_we,
   input logic [1:0]   csr_addr,
   input logic [30:0]  csr_wdata
);
   import utsph_pkg::*;

   // a kind that means nothing never leaves the block
   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_VERTEX || rsp_tuser == KIND_TRIANGLE ||
                      rsp_tuser == KIND_RANGE))
      else $error("unknown record kind");

   // out-of-range word is alone and empty
   a_range_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_RANGE) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("bad out-of-range word");

   // triangle words carry no normal
   a_tri_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_TRIANGLE) |-> (rsp_tdata[143:96] == '0))
      else $error("triangle word with normal");

   // a word taken that is not last is followed by a triangle word
   a_tri_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tuser == KIND_TRIANGLE))
      else $error("missing triangle word");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result word changed under stall");

endmodule

bind uv_sphere_tessellator utsph_checker u_checker (.*);
